// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the order rate window limiter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: rtl/orwl_pkg.sv
// ---------------------------------------------------------------------------
// orwl_pkg
// Shared constants, types and helper functions of the order rate limiter.
// ---------------------------------------------------------------------------
package orwl_pkg;

   // Ring geometry.
   localparam int RING_DEPTH = 64;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // Field widths.
   localparam int KIND_W      = 2;
   localparam int STAMP_W     = 63;
   localparam int WINDOW_W    = 62;
   localparam int MAX_W       = 6;
   localparam int RSP_COUNT_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CMP_W       = (CNT_W > MAX_W) ? CNT_W : MAX_W;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ORDERS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW     = 2'd2;

   // Register reset values.
   localparam logic                ENABLE_RESET     = 1'b1;
   localparam logic [MAX_W-1:0]    MAX_ORDERS_RESET = 6'd60;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 62'd60_000_000_000;

   // Access to the timestamp memory.
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [STAMP_W-1:0] wr_data;
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
   } stamp_mem_req_type;

   // Next slot around the ring.
   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] res;
      if (slot == SLOT_W'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = slot + SLOT_W'(1);
      end
      return res;
   endfunction

   // Slot that lies a given count past the oldest one (count below depth).
   function automatic logic [SLOT_W-1:0] slot_offset(input logic [SLOT_W-1:0] slot,
                                                     input logic [CNT_W-1:0]  count);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(slot) + (CNT_W + 1)'(count);
      if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(RING_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

// File: rtl/orwl_stamp_store.sv
// ---------------------------------------------------------------------------
// orwl_stamp_store
// Timestamp ring memory: one write port and one read port, with
// registered read data.
// ---------------------------------------------------------------------------
module orwl_stamp_store (
   input  logic                       clock,
   input  orwl_pkg::stamp_mem_req_type mem_req,
   output logic [orwl_pkg::STAMP_W-1:0] rd_data
);
   import orwl_pkg::*;

   logic [STAMP_W-1:0] stamp_mem [RING_DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         stamp_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= stamp_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/order_rate_window_limiter_unit.sv
// ---------------------------------------------------------------------------
// order_rate_window_limiter_unit
// Sliding-window order rate limiter over a ring of timestamps in memory.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_stall  | req_kind, req_time_now
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_verdict, rsp_window_count
//  csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// A check that reads the ring goes from acceptance through ST_PRUNE, which
// drops expired head entries one entry per cycle, to ST_EMIT, which loads
// the result; any other request goes from acceptance straight to ST_EMIT.
// Reset clears the ring pointers and the control state; no clearing pass.
// One request is in work at a time; a loaded result waits in the output
// register under rsp_stall while the next request is accepted.
// ---------------------------------------------------------------------------
module order_rate_window_limiter_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [orwl_pkg::KIND_W-1:0]        req_kind,
   input  logic [orwl_pkg::STAMP_W-1:0]       req_time_now,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_verdict,
   output logic [orwl_pkg::RSP_COUNT_W-1:0]   rsp_window_count,
   // Configuration port.
   input  logic                               csr_wr_en,
   input  logic [orwl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [orwl_pkg::WINDOW_W-1:0]      csr_wr_data
);
   import orwl_pkg::*;

`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRUNE = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STAMP_W-1:0]  cutoff_ff, cutoff_in;
   logic                judge_ff, judge_in;

   logic                enable_ff;
   logic [MAX_W-1:0]    max_orders_ff;
   logic [WINDOW_W-1:0] window_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_verdict_ff, rsp_verdict_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   stamp_mem_req_type   mem_req;
   logic [STAMP_W-1:0]  rd_data;

   logic                req_accept;
   logic                rsp_free;
   logic [STAMP_W-1:0]  window_ext;
   logic                expired;
   logic [CNT_W-1:0]    count_dec;
   logic [SLOT_W-1:0]   oldest_inc;

   // Ring memory.
   orwl_stamp_store u_stamp_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign window_ext = {1'b0, window_ff};
   assign expired    = (rd_data < cutoff_ff);
   assign count_dec  = count_ff - CNT_W'(1);
   assign oldest_inc = slot_next(oldest_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= ENABLE_RESET;
         max_orders_ff <= MAX_ORDERS_RESET;
         window_ff     <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENABLE:     enable_ff     <= csr_wr_data[0];
            REG_MAX_ORDERS: max_orders_ff <= csr_wr_data[MAX_W-1:0];
            REG_WINDOW:     window_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequencer: accept, prune the ring head one entry per cycle, emit.
   always_comb begin
      state_in       = state_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      cutoff_in      = cutoff_ff;
      judge_in       = judge_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_count_in   = rsp_count_ff;
      mem_req        = '0;
      mem_req.wr_data = req_time_now;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in  = ST_EMIT;
               judge_in  = 1'b0;
               cutoff_in = req_time_now - window_ext;
               case (req_kind)
                  KIND_CHECK: begin
                     judge_in = enable_ff;
                     // Prune only when the cutoff lies at or above zero.
                     if (enable_ff && (req_time_now >= window_ext) &&
                         (count_ff != '0)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = oldest_ff;
                        state_in        = ST_PRUNE;
                     end
                  end
                  KIND_RECORD: begin
                     mem_req.wr_en = 1'b1;
                     if (count_ff == CNT_W'(RING_DEPTH)) begin
                        // Full ring: the new stamp overwrites the oldest one.
                        mem_req.wr_addr = oldest_ff;
                        oldest_in       = oldest_inc;
                     end else begin
                        mem_req.wr_addr = slot_offset(oldest_ff, count_ff);
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_CLEAR: begin
                     oldest_in = '0;
                     count_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PRUNE: begin
            // Head entry is in rd_data; drop it while it is expired.
            if (expired) begin
               oldest_in = oldest_inc;
               count_in  = count_dec;
               if (count_dec != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = oldest_inc;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = judge_ff && (CMP_W'(count_ff) > CMP_W'(max_orders_ff));
               rsp_count_in   = RSP_COUNT_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cutoff_ff      <= cutoff_in;
      judge_ff       <= judge_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_window_count = rsp_count_ff;

   // The stored count never exceeds the ring depth.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RING_DEPTH))
   // Pruning only runs on a nonempty ring.
   `ASSERT_SAME(a_prune_nonempty, clock, reset, state_ff == ST_PRUNE, count_ff != '0)
   // An accepted request always leaves the idle state.
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != ST_IDLE)
   // Each pruning step drops exactly one entry.
   `ASSERT_NEXT(a_prune_step, clock, reset, (state_ff == ST_PRUNE) && expired,
                count_ff == $past(count_ff) - CNT_W'(1))

endmodule

// File: verif/tb_order_rate_window_limiter_unit.sv
// ---------------------------------------------------------------------------
// tb_order_rate_window_limiter_unit
// Self-checking bench for the sliding-window order rate limiter. A shadow
// copy of the timestamp ring and the limit registers predicts the verdict and
// window count of every accepted request. Results are compared in order. A
// short directed table covers empty, full and pruning corner cases. Random
// traffic follows under several register settings and idle patterns.
// ---------------------------------------------------------------------------
module tb_order_rate_window_limiter_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import orwl_pkg::*;

   localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED  = 2'd3;
   localparam logic [STAMP_W-1:0]     STAMP_MAX   = {STAMP_W{1'b1}};
   localparam logic [WINDOW_W-1:0]    WINDOW_MAX  = {WINDOW_W{1'b1}};

   localparam int ITEMS_PER_SETTING  = 147;
   localparam int SETTINGS_PER_PHASE = 4;
   localparam int NUM_PHASES         = 3;
   localparam int DRAIN_CYCLES       = 80;
   localparam int CYCLE_LIMIT        = 1_000_000;
   localparam int NUM_ROWS           = 26;

   typedef struct packed {
      logic                   verdict;
      logic [RSP_COUNT_W-1:0] window_count;
   } rate_result_type;

   // One row of the directed table. Register values apply only when
   // set_cfg is high; the result is typed in only when pinned is high.
   typedef struct packed {
      bit                   set_cfg;
      bit                   cfg_enable;
      bit [MAX_W-1:0]       cfg_max;
      bit [WINDOW_W-1:0]    cfg_window;
      bit [KIND_W-1:0]      kind;
      bit [STAMP_W-1:0]     stamp;
      bit [7:0]             reps;
      bit                   pinned;
      bit                   exp_verdict;
      bit [RSP_COUNT_W-1:0] exp_count;
   } directed_row_type;

   directed_row_type directed_table [NUM_ROWS] = '{
      // Empty ring right after reset, clear and unused kind at the time extreme.
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd0,     8'd1, 1'b1, 1'b0, 7'd0},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CLEAR,  63'd0,     8'd1, 1'b1, 1'b0, 7'd0},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_UNUSED, STAMP_MAX, 8'd1, 1'b1, 1'b0, 7'd0},
      // Small window: window longer than time, then head pruning.
      '{1'b1, 1'b1, 6'd2,  62'd100, KIND_RECORD, 63'd10,    8'd1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, 63'd20,    8'd1, 1'b1, 1'b0, 7'd2},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, 63'd30,    8'd1, 1'b1, 1'b0, 7'd3},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd50,    8'd1, 1'b1, 1'b1, 7'd3},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd125,   8'd1, 1'b1, 1'b0, 7'd1},
      // An out of order stamp stays behind a live head entry.
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, 63'd125,   8'd1, 1'b1, 1'b0, 7'd2},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, 63'd5,     8'd1, 1'b1, 1'b0, 7'd3},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd131,   8'd1, 1'b1, 1'b0, 7'd2},
      // Disabled: records still store, checks pass without pruning.
      '{1'b1, 1'b0, 6'd2,  62'd100, KIND_RECORD, 63'd200,   8'd1, 1'b1, 1'b0, 7'd3},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd10000, 8'd1, 1'b1, 1'b0, 7'd3},
      // Zero window and zero limit: only stamps at or after now survive.
      '{1'b1, 1'b1, 6'd0,  62'd0,   KIND_CHECK,  63'd200,   8'd1, 1'b1, 1'b1, 7'd1},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd201,   8'd1, 1'b1, 1'b0, 7'd0},
      // Largest window and limit: fill the ring, overflow it, then prune all.
      '{1'b1, 1'b1, 6'd63, WINDOW_MAX, KIND_RECORD, 63'd1000, 8'd64, 1'b0, 1'b0, 7'd0},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, 63'd1001,  8'd1, 1'b1, 1'b0, 7'd64},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd2000,  8'd1, 1'b1, 1'b1, 7'd64},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  STAMP_MAX, 8'd1, 1'b1, 1'b0, 7'd0},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_RECORD, STAMP_MAX, 8'd1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_UNUSED, 63'd0,     8'd1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CLEAR,  STAMP_MAX, 8'd1, 1'b1, 1'b0, 7'd0},
      // Back to the reset settings, then the shortest nonzero window.
      '{1'b1, 1'b1, MAX_ORDERS_RESET, WINDOW_RESET, KIND_RECORD, 63'd0, 8'd1, 1'b1, 1'b0, 7'd1},
      '{1'b1, 1'b1, 6'd1,  62'd1,   KIND_RECORD, 63'd2,     8'd1, 1'b1, 1'b0, 7'd2},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CHECK,  63'd3,     8'd1, 1'b1, 1'b0, 7'd1},
      '{1'b0, 1'b0, 6'd0,  62'd0,   KIND_CLEAR,  63'd3,     8'd1, 1'b1, 1'b0, 7'd0}
   };

   // Idle percentages per phase: sender light and receiver heavy, then swapped, then no idle.
   int unsigned phase_send_idle [NUM_PHASES] = '{19, 73, 0};
   int unsigned phase_rsp_idle  [NUM_PHASES] = '{73, 19, 0};

   // Block ports.
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind         = KIND_CHECK;
   logic [STAMP_W-1:0]     req_time_now     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_verdict;
   logic [RSP_COUNT_W-1:0] rsp_window_count;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = REG_ENABLE;
   logic [WINDOW_W-1:0]    csr_wr_data      = '0;

   // Typed expectation that travels with a directed request.
   logic                   pin_valid        = 1'b0;
   rate_result_type        pin_result       = '0;

   int unsigned            send_idle_pct    = 0;
   int unsigned            rsp_idle_pct     = 0;

   // Shadow copy of the ring and the limit registers.
   logic [STAMP_W-1:0]     shadow_stamps [RING_DEPTH];
   logic [SLOT_W-1:0]      shadow_head      = '0;
   int                     shadow_fill      = 0;
   logic                   lim_enable       = ENABLE_RESET;
   logic [MAX_W-1:0]       lim_max          = MAX_ORDERS_RESET;
   logic [WINDOW_W-1:0]    lim_window       = WINDOW_RESET;

   rate_result_type        pending_rate_results [$];
   rate_result_type        predicted_result;
   rate_result_type        oldest_due;

   int                     mismatch_count   = 0;
   int                     results_checked  = 0;
   int                     rejects_seen     = 0;
   int                     requests_sent    = 0;
   int                     config_settings  = 0;
   int                     cycle_count      = 0;

   order_rate_window_limiter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_time_now     (req_time_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_window_count (rsp_window_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // Advance the shadow ring by one request and return its expected result.
   function automatic rate_result_type predict_rate_result(input logic [KIND_W-1:0]  kind,
                                                           input logic [STAMP_W-1:0] stamp);
      rate_result_type    res;
      logic [STAMP_W-1:0] cutoff;
      res = '0;
      case (kind)
         KIND_CHECK: begin
            if (lim_enable) begin
               // Nothing expires while the window reaches below time zero.
               if (stamp >= STAMP_W'(lim_window)) begin
                  cutoff = stamp - STAMP_W'(lim_window);
                  while (shadow_fill > 0 && shadow_stamps[shadow_head] < cutoff) begin
                     shadow_head = SLOT_W'((int'(shadow_head) + 1) % RING_DEPTH);
                     shadow_fill--;
                  end
               end
               res.verdict = (shadow_fill > int'(lim_max));
            end
         end
         KIND_RECORD: begin
            // A full ring gives up its oldest stamp first.
            if (shadow_fill >= RING_DEPTH) begin
               shadow_head = SLOT_W'((int'(shadow_head) + 1) % RING_DEPTH);
               shadow_fill = RING_DEPTH - 1;
            end
            shadow_stamps[(int'(shadow_head) + shadow_fill) % RING_DEPTH] = stamp;
            shadow_fill++;
         end
         KIND_CLEAR: begin
            shadow_head = '0;
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      res.window_count = RSP_COUNT_W'(shadow_fill);
      return res;
   endfunction

   // Offer one request after a random gap and hold it until it is taken.
   task automatic offer_request(input logic [KIND_W-1:0]  kind,
                                input logic [STAMP_W-1:0] stamp,
                                input logic               pinned,
                                input rate_result_type    pinned_res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_time_now <= stamp;
      pin_valid    <= pinned;
      pin_result   <= pinned_res;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // Stop offering and wait until every pending result has come back.
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rate_results.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [WINDOW_W-1:0]    data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Registers change only while the block has nothing in flight.
   task automatic program_limits(input logic                en,
                                 input logic [MAX_W-1:0]    max_count,
                                 input logic [WINDOW_W-1:0] window);
      settle_idle();
      write_register(REG_ENABLE, WINDOW_W'(en));
      write_register(REG_MAX_ORDERS, WINDOW_W'(max_count));
      write_register(REG_WINDOW, window);
      csr_wr_en <= 1'b0;
      config_settings++;
   endtask

   // Clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Shadow register writes, result checking and prediction on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ENABLE:     lim_enable = csr_wr_data[0];
               REG_MAX_ORDERS: lim_max    = csr_wr_data[MAX_W-1:0];
               REG_WINDOW:     lim_window = csr_wr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rate_results.size() == 0) begin
               $display("%0t: result with none pending: verdict %0d count %0d",
                        $time, rsp_verdict, rsp_window_count);
               mismatch_count++;
            end else begin
               oldest_due = pending_rate_results.pop_front();
               if (rsp_verdict !== oldest_due.verdict) begin
                  $display("%0t: verdict mismatch: expected %0d, actual %0d",
                           $time, oldest_due.verdict, rsp_verdict);
                  mismatch_count++;
               end
               if (rsp_window_count !== oldest_due.window_count) begin
                  $display("%0t: window count mismatch: expected %0d, actual %0d",
                           $time, oldest_due.window_count, rsp_window_count);
                  mismatch_count++;
               end
               if (rsp_verdict === 1'b1) begin
                  rejects_seen++;
               end
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            predicted_result = predict_rate_result(req_kind, req_time_now);
            pending_rate_results.insert(pending_rate_results.size(),
                                        pin_valid ? pin_result : predicted_result);
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Watchdog expired after %0d cycles with %0d results pending.",
               cycle_count, pending_rate_results.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus.
   initial begin
      int                 row;
      int                 rep;
      int                 phase;
      int                 setting;
      int                 item;
      int unsigned        roll;
      logic [63:0]        time_base;
      logic [63:0]        step;
      logic [63:0]        next_time;
      logic [STAMP_W-1:0] stamp;
      logic [KIND_W-1:0]  kind;
      logic               en;
      logic [MAX_W-1:0]   max_count;
      logic [WINDOW_W-1:0] window;
      rate_result_type    typed_res;

      send_idle_pct = phase_send_idle[0];
      rsp_idle_pct  = phase_rsp_idle[0];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (row = 0; row < NUM_ROWS; row++) begin
         if (directed_table[row].set_cfg) begin
            program_limits(directed_table[row].cfg_enable, directed_table[row].cfg_max,
                           directed_table[row].cfg_window);
         end
         typed_res.verdict      = directed_table[row].exp_verdict;
         typed_res.window_count = directed_table[row].exp_count;
         for (rep = 0; rep < int'(directed_table[row].reps); rep++) begin
            offer_request(directed_table[row].kind, directed_table[row].stamp,
                          directed_table[row].pinned, typed_res);
         end
      end

      // The unused register index must leave every limit untouched.
      settle_idle();
      write_register(REG_UNUSED, WINDOW_MAX);
      csr_wr_en <= 1'b0;

      // Random traffic: mostly nondecreasing stamps with some noise.
      time_base = 64'd0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = phase_send_idle[phase];
         rsp_idle_pct <= phase_rsp_idle[phase];
         for (setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
            en        = 1'b1;
            max_count = MAX_W'($urandom_range(63));
            case ((phase * SETTINGS_PER_PHASE + setting) % 6)
               0: begin
                  max_count = MAX_ORDERS_RESET;
                  window    = WINDOW_RESET;
               end
               1: begin
                  max_count = '0;
                  window    = 62'd1;
               end
               2: begin
                  max_count = '1;
                  window    = WINDOW_MAX;
               end
               3: begin
                  en     = 1'b0;
                  window = WINDOW_W'({$urandom, $urandom});
               end
               4: window = WINDOW_W'({$urandom, $urandom});
               default: window = WINDOW_W'($urandom_range(1000));
            endcase
            program_limits(en, max_count, window);

            for (item = 0; item < ITEMS_PER_SETTING; item++) begin
               roll = $urandom_range(99);
               kind = (roll < 2) ? KIND_CLEAR : (roll < 4) ? KIND_UNUSED :
                      (roll < 50) ? KIND_RECORD : KIND_CHECK;
               // Step sizes scale with the window so the count keeps moving.
               roll = $urandom_range(99);
               if (roll < 15) begin
                  step = 64'd0;
               end else if (roll < 97) begin
                  step = {$urandom, $urandom} %
                         ((64'(window) >> $urandom_range(1, 8)) + 64'd2);
               end else begin
                  step = 64'(window) + ({$urandom, $urandom} % (64'(window) + 64'd1)) + 64'd1;
               end
               next_time = time_base + step;
               if (next_time > 64'(STAMP_MAX)) begin
                  // Time ran out: start low again with an empty ring.
                  kind      = KIND_CLEAR;
                  next_time = 64'($urandom_range(1000));
               end
               time_base = next_time;
               stamp     = STAMP_W'(time_base);
               roll      = $urandom_range(99);
               if (roll < 2) begin
                  stamp = STAMP_W'({$urandom, $urandom});
               end else if (roll < 5) begin
                  stamp = stamp - STAMP_W'({$urandom, $urandom} % (time_base + 64'd1));
               end
               offer_request(kind, stamp, 1'b0, '0);
            end
         end
      end

      // Drain and report.
      settle_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests and checked %0d results (%0d rejections).",
               requests_sent, results_checked, rejects_seen);
      $display("Used %0d register settings across three back-pressure phases.",
               config_settings);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: order_rate_window_limiter_unit.f
+incdir+rtl
rtl/orwl_pkg.sv
rtl/orwl_stamp_store.sv
rtl/order_rate_window_limiter_unit.sv
verif/tb_order_rate_window_limiter_unit.sv
